[hw/rtl/hot_address_counter_table_core_assert.svh]
// Assertion macros for the hot address counter table.
// Each macro samples on clock and is disabled while reset is high.
`ifndef HOT_ADDRESS_COUNTER_TABLE_CORE_ASSERT_SVH
`define HOT_ADDRESS_COUNTER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define HACT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HACT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/hact_pkg.sv]
// Shared constants, types and helpers for the hot address counter table.
// No dependencies; imported by the interfaces and all modules.
package hact_pkg;

   // Table geometry (TABLE_ENTRIES must be a power of two)
   localparam int TABLE_ENTRIES  = 1024;
   localparam int SLOT_BITS      = $clog2(TABLE_ENTRIES);
   localparam int PC_BITS        = 64;
   localparam int PC_SHIFT       = 2;
   localparam int COUNT_BITS     = 16;
   localparam int OUT_COUNT_BITS = 16;
   localparam int THRESH_BITS    = 16;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);

   // Table sequencer states
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } seq_state_type;

   // One table entry
   typedef struct packed {
      logic [PC_BITS-1:0]    tag;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // One result beat
   typedef struct packed {
      logic                      hot;
      logic                      owned;
      logic [OUT_COUNT_BITS-1:0] slot_count;
   } result_type;

   // Clip the stored count to the reported width
   function automatic logic [OUT_COUNT_BITS-1:0] clip_count(logic [COUNT_BITS-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return (wide > 32'(65535)) ? {OUT_COUNT_BITS{1'b1}} : wide[OUT_COUNT_BITS-1:0];
   endfunction

endpackage

[hw/rtl/hact_if.sv]
// Valid/ready channel interfaces for the hot address counter table.
// Depends on hact_pkg for field widths.
interface hact_req_if import hact_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PC_BITS-1:0] pc;

   modport source (output valid, output pc, input ready);
   modport sink   (input valid, input pc, output ready);
endinterface

interface hact_rsp_if import hact_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      hot;
   logic                      owned;
   logic [OUT_COUNT_BITS-1:0] slot_count;

   modport source (output valid, output hot, output owned, output slot_count, input ready);
   modport sink   (input valid, input hot, input owned, input slot_count, output ready);
endinterface

[hw/rtl/hact_slot_update.sv]
// Majority-vote update of one table entry and the result it yields.
// Depends on hact_pkg for entry and result types.
module hact_slot_update import hact_pkg::*; (
   input  logic [PC_BITS-1:0]     pc,
   input  entry_type              entry_cur,
   input  logic [THRESH_BITS-1:0] threshold,
   output entry_type              entry_new,
   output result_type             result
);

   logic tag_match;
   logic count_zero;
   logic owned;

   assign tag_match  = (entry_cur.tag == pc);
   assign count_zero = (entry_cur.count == '0);
   assign owned      = tag_match || count_zero;

   // Count up on a hit, claim an empty slot, decay otherwise
   always_comb begin
      entry_new = entry_cur;
      if (tag_match) begin
         if (entry_cur.count != COUNT_MAX) begin
            entry_new.count = entry_cur.count + COUNT_BITS'(1);
         end
      end else if (count_zero) begin
         entry_new.tag   = pc;
         entry_new.count = COUNT_BITS'(1);
      end else begin
         entry_new.count = entry_cur.count - COUNT_BITS'(1);
      end
   end

   // Report against the updated entry
   assign result.owned      = owned;
   assign result.hot        = owned && (32'(entry_new.count) >= 32'(threshold));
   assign result.slot_count = clip_count(entry_new.count);

endmodule

[hw/rtl/hot_address_counter_table_core.sv]
// Hot address counter table: direct-mapped tag/count store with majority-vote replacement.
// Each accepted request goes through the update stage, then the output register.
// Throughput: one beat per cycle while rsp_bus.ready allows; the read/modify/write of the
// one-read one-write entry memory sets this, with a one-entry forward covering back-to-back
// hits on the same slot. Reset: synchronous; afterwards a clearing pass zeroes every entry
// of the table while req_bus.ready stays low; csr writes are taken throughout.
module hot_address_counter_table_core import hact_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   hact_req_if.sink               req_bus,
   hact_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [THRESH_BITS-1:0] csr_wr_data
);

`include "hot_address_counter_table_core_assert.svh"

   // Sequencer
   seq_state_type          state_ff, state_in;
   logic [SLOT_BITS-1:0]   clr_idx_ff, clr_idx_in;
   logic                   clearing;

   // Threshold register
   logic [THRESH_BITS-1:0] thresh_ff, thresh_in;

   // Update stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [PC_BITS-1:0]     s1_pc_ff;
   logic [SLOT_BITS-1:0]   s1_slot;
   logic                   s1_adv;
   logic                   s1_fire;
   logic                   req_fire;
   logic [SLOT_BITS-1:0]   req_slot;

   // Entry memory
   entry_type              slot_mem [TABLE_ENTRIES];
   entry_type              rd_data_ff;
   logic                   mem_we;
   logic [SLOT_BITS-1:0]   mem_addr;
   entry_type              mem_wdata;

   // Forwarding of the last write
   logic                   wr_valid_ff, wr_valid_in;
   logic [SLOT_BITS-1:0]   wr_slot_ff;
   entry_type              wr_entry_ff;
   entry_type              entry_cur;
   entry_type              entry_new;
   result_type             result;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff;

   // Sequence the clearing pass, then run
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      clearing   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing   = 1'b1;
            clr_idx_in = clr_idx_ff + SLOT_BITS'(1);
            if (clr_idx_ff == SLOT_BITS'(TABLE_ENTRIES - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Handshake and stage advance
   assign s1_adv        = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && s1_adv;
   assign req_bus.ready = !clearing && (!s1_valid_ff || s1_adv);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_slot      = req_bus.pc[PC_SHIFT +: SLOT_BITS];
   assign s1_slot       = s1_pc_ff[PC_SHIFT +: SLOT_BITS];

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   assign wr_valid_in  = s1_fire ? 1'b1 : (clearing ? 1'b0 : wr_valid_ff);
   assign thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;

   // Use the last write when it hit the slot being updated
   assign entry_cur = (wr_valid_ff && (wr_slot_ff == s1_slot)) ? wr_entry_ff : rd_data_ff;

   hact_slot_update u_update (
      .pc        (s1_pc_ff),
      .entry_cur (entry_cur),
      .threshold (thresh_ff),
      .entry_new (entry_new),
      .result    (result)
   );

   // Write port: clearing pass or write-back
   assign mem_we    = clearing || s1_fire;
   assign mem_addr  = clearing ? clr_idx_ff : s1_slot;
   assign mem_wdata = clearing ? '0 : entry_new;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         thresh_ff    <= THRESH_RESET;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         thresh_ff    <= thresh_in;
         s1_valid_ff  <= s1_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pc_ff <= req_bus.pc;
      end
      if (s1_fire) begin
         wr_slot_ff  <= s1_slot;
         wr_entry_ff <= entry_new;
         rsp_data_ff <= result;
      end
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= slot_mem[req_slot];
      end
   end

   // Drive the result channel
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hot        = rsp_data_ff.hot;
   assign rsp_bus.owned      = rsp_data_ff.owned;
   assign rsp_bus.slot_count = rsp_data_ff.slot_count;

   `HACT_ASSERT_IMP(a_idle_while_clearing, clearing, !s1_valid_ff && !rsp_valid_ff,
      "item in flight during clearing pass")
   `HACT_ASSERT_NXT(a_stage_holds, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_pc_ff),
      "update stage lost its item while stalled")
   `HACT_ASSERT_IMP(a_hot_needs_owner, rsp_valid_ff && rsp_data_ff.hot, rsp_data_ff.owned,
      "hot reported for a slot not owned")
   `HACT_ASSERT_IMP(a_owner_counts, rsp_valid_ff && rsp_data_ff.owned,
      rsp_data_ff.slot_count != '0, "owned slot reported with zero count")

endmodule
